// ===== src/fwt_pkg.sv =====
// ----------------------------------------------------------------------------
// fwt_pkg
// shared widths, controller state and command/status types for the
// binary indexed tree block
// ----------------------------------------------------------------------------
package fwt_pkg;

  // tree storage
  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);

  // word fields
  localparam int IDX_W  = 11;
  localparam int DATA_W = 32;
  // walk position, one bit wider so an upward step past the top is seen
  localparam int POS_W  = IDX_W + 1;

  // register reset
  localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(1024);

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } fwt_state_e;

  typedef struct packed {
    logic clear;  // write zero at sweep address
    logic load;   // take input word
    logic issue;  // read cell at walk position and step
    logic put;    // move sum into output register
  } fwt_cmd_t;

  typedef struct packed {
    logic clr_last;  // sweep at last cell
    logic more;      // walk position still inside the tree
    logic is_query;
    logic out_busy;  // output register holds an untaken word
  } fwt_status_t;

endpackage

// ===== src/fwt_in_if.sv =====
// ----------------------------------------------------------------------------
// fwt_in_if
// input channel: operation, index and delta with valid/ready
// ----------------------------------------------------------------------------
interface fwt_in_if import fwt_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] delta;

  modport source (output valid, output operation, output index, output delta,
                  input ready);
  modport sink   (input valid, input operation, input index, input delta,
                  output ready);

endinterface

// ===== src/fwt_out_if.sv =====
// ----------------------------------------------------------------------------
// fwt_out_if
// output channel: prefix sum with valid/ready
// ----------------------------------------------------------------------------
interface fwt_out_if import fwt_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] prefix_sum;

  modport source (output valid, output prefix_sum, input ready);
  modport sink   (input valid, input prefix_sum, output ready);

endinterface

// ===== src/fwt_ram.sv =====
// ----------------------------------------------------------------------------
// fwt_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwt_ctrl
// sequencer: clearing sweep, word accept, tree walk and result hand-off
// ----------------------------------------------------------------------------
module fwt_ctrl import fwt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  fwt_status_t status_i,
  output fwt_cmd_t    cmd_o
);

  fwt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.more) begin
          cmd_o.issue = 1'b1;
        end else if (status_i.is_query) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.put = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/fwt_datapath.sv =====
// ----------------------------------------------------------------------------
// fwt_datapath
// size register, walk position, accumulator, cell store and output register
// ----------------------------------------------------------------------------
module fwt_datapath import fwt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fwt_cmd_t                 cmd_i,
  output fwt_status_t              status_o,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_wdata_i,
  input  logic                     operation_i,
  input  logic [IDX_W-1:0]         index_i,
  input  logic signed [DATA_W-1:0] delta_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] prefix_sum_o
);

  logic [IDX_W-1:0]  size_q;
  logic [POS_W-1:0]  limit;
  logic [POS_W-1:0]  index_ext;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  pos_m1;
  logic [POS_W-1:0]  low_bit;
  logic              op_q;
  logic [DATA_W-1:0] delta_q;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              rd_pend_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [DATA_W-1:0] rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;

  // active size saturates at the store depth
  always_comb begin
    if ({1'b0, size_q} > POS_W'(MAX_ENTRIES)) begin
      limit = POS_W'(MAX_ENTRIES);
    end else begin
      limit = {1'b0, size_q};
    end
  end

  assign index_ext = {1'b0, index_i};
  assign pos_m1    = pos_q - POS_W'(1);
  assign low_bit   = pos_q & (~pos_q + POS_W'(1));

  // next position and accumulator
  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = '0;
      if (operation_i == OP_QUERY && index_ext > limit) begin
        pos_d = limit;
      end else begin
        pos_d = index_ext;
      end
    end else if (cmd_i.issue) begin
      if (op_q == OP_QUERY) begin
        pos_d = pos_q - low_bit;
      end else begin
        pos_d = pos_q + low_bit;
      end
    end
    if (rd_pend_q && op_q == OP_QUERY) begin
      acc_d = acc_q + rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      rd_pend_q   <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      rd_pend_q <= cmd_i.issue;
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.put) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    acc_q <= acc_d;
    if (cmd_i.load) begin
      op_q    <= operation_i;
      delta_q <= delta_i;
    end
    if (cmd_i.issue) begin
      rd_addr_q <= pos_m1[ADDR_W-1:0];
    end
    if (cmd_i.put) begin
      out_data_q <= acc_q;
    end
  end

  // write port: clearing sweep, or read-modify-write of an update walk
  always_comb begin
    if (cmd_i.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = rd_pend_q && (op_q == OP_UPDATE);
      ram_waddr = rd_addr_q;
      ram_wdata = rdata + delta_q;
    end
  end

  fwt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_m1[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign status_o.clr_last = (clr_addr_q == ADDR_W'(MAX_ENTRIES - 1));
  assign status_o.is_query = (op_q == OP_QUERY);
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign status_o.more     = (op_q == OP_QUERY) ? (pos_q != '0)
                           : ((pos_q != '0) && (pos_q <= limit));

  assign out_valid_o  = out_valid_q;
  assign prefix_sum_o = out_data_q;

endmodule

// ===== src/fenwick_tree_update_prefix_sum.sv =====
// ----------------------------------------------------------------------------
// fenwick_tree_update_prefix_sum
// binary indexed tree of 32-bit wrapping counts with point update and
// prefix-sum query
// ----------------------------------------------------------------------------
// A word is accepted only while the block is idle and is worked on alone.
// The walk touches one tree cell per cycle through the cell ram (one read
// and one write port); a path holds at most 11 cells for 1024 entries
// (popcount-style). An update at index zero or above the active size
// walks no cell and changes nothing. A query whose sum finds the output
// register still full waits there until the word is taken. After reset a
// clearing sweep writes zero into all 1024 cells, one per cycle, and no
// word is accepted during the sweep; size writes are taken at any time.
// ----------------------------------------------------------------------------
module fenwick_tree_update_prefix_sum import fwt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // size register write
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_wdata_i,
  // operation word in
  fwt_in_if.sink           in_i,
  // prefix sum word out
  fwt_out_if.source        out_o
);

  fwt_cmd_t    cmd;
  fwt_status_t status;

  // sequencer owns the handshake and the ordering of steps
  fwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath holds all payload, the cell store and the output register
  fwt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .operation_i  (in_i.operation),
    .index_i      (in_i.index),
    .delta_i      (in_i.delta),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .prefix_sum_o (out_o.prefix_sum)
  );

endmodule
